FILE: rtl/vrta_pkg.sv
// Package for the voice relay talker arbiter: payload structs, codes, sizes.
// No dependencies.
package vrta_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned MaskW = 16;
  localparam int unsigned SrcW = 4;
  localparam int unsigned MsPerSec = 1000;

  localparam logic [2:0] ActNone   = 3'd0;
  localparam logic [2:0] ActHeader = 3'd1;
  localparam logic [2:0] ActData   = 3'd2;
  localparam logic [2:0] ActStatus = 3'd3;
  localparam logic [2:0] ActTick   = 3'd4;

  localparam logic [2:0] OutOk       = 3'd0;
  localparam logic [2:0] OutBadTag   = 3'd1;
  localparam logic [2:0] OutShort    = 3'd2;
  localparam logic [2:0] OutFull     = 3'd3;
  localparam logic [2:0] OutBusy     = 3'd4;
  localparam logic [2:0] OutNotActv  = 3'd5;
  localparam logic [2:0] OutIgnored  = 3'd6;

  localparam logic [1:0] CauseNone  = 2'd0;
  localparam logic [1:0] CauseEot   = 2'd1;
  localparam logic [1:0] CauseEvict = 2'd2;
  localparam logic [1:0] CauseWdog  = 2'd3;

  localparam logic [1:0] KindPoll   = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindData   = 2'd2;

  localparam logic [2:0] RegClientTo  = 3'd0;
  localparam logic [2:0] RegTalkerTo  = 3'd1;
  localparam logic [2:0] RegStatusEn  = 3'd2;
  localparam logic [2:0] RegStatusInt = 3'd3;
  localparam logic [2:0] RegHdrMin    = 3'd4;
  localparam logic [2:0] RegDataMin   = 3'd5;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_msec;
    logic        tag_ok;
    logic [1:0]  pkt_kind;
    logic [15:0] pkt_len;
    logic [47:0] addr_key;
    logic [15:0] stream_id;
    logic        end_flag;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] dest_mask;
    logic [3:0]  src_slot;
    logic [2:0]  outcome;
    logic        released;
    logic [1:0]  release_cause;
    logic [15:0] evicted_mask;
  } out_word_t;

endpackage

FILE: rtl/vrta_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module vrta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/voice_relay_talker_arbiter_top.sv
// Voice relay talker arbiter. Each accepted word passes through a read-setup
// step, a slot scan that reads one slot a cycle through the slot RAMs, a compute
// step, an output step and a return to idle before the next acceptance; output
// stalls hold the output step. Depends on vrta_pkg and vrta_ram.
//
// One word is processed at a time; in_stall_o is high from acceptance until the
// result has left the output register. Ticks and packets both scan every slot
// once; the scan compares one slot per cycle against the key and timeouts.
module voice_relay_talker_arbiter_top
  import vrta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {StIdle, StRead, StScan, StDone, StOut} state_e;
  localparam logic [SlotW:0] LastIdx = (SlotW+1)'(NumSlots - 1);

  state_e st_q;
  in_word_t in_q;
  logic [15:0] cto_q, tto_q, sint_q, hmin_q, dmin_q;
  logic sen_q;
  logic [NumSlots-1:0] used_q, evict_q;
  logic talk_q;
  logic [SlotW-1:0] tslot_q;
  logic [15:0] astream_q;
  logic [31:0] lft_q;
  logic [SlotW:0] cnt_q;
  logic [SlotW-1:0] rd_idx_q;
  logic hit_q, free_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  logic [31:0] hit_stat_q;
  logic [31:0] limit_q, sint_ms_q;
  out_word_t out_q;

  logic [47:0] ra_addr;
  logic [31:0] ra_poll, ra_stat;
  logic        we_addr, we_poll, we_stat;
  logic [SlotW-1:0] wa_idx;
  logic [31:0] w_stat;

  vrta_ram #(.Width(48), .Depth(NumSlots)) u_addr (
    .clk_i, .we_i(we_addr), .waddr_i(wa_idx), .wdata_i(in_q.addr_key),
    .raddr_i(rd_idx_q), .rdata_o(ra_addr));
  vrta_ram #(.Width(32), .Depth(NumSlots)) u_poll (
    .clk_i, .we_i(we_poll), .waddr_i(wa_idx), .wdata_i(in_q.now_msec),
    .raddr_i(rd_idx_q), .rdata_o(ra_poll));
  vrta_ram #(.Width(32), .Depth(NumSlots)) u_stat (
    .clk_i, .we_i(we_stat), .waddr_i(wa_idx), .wdata_i(w_stat),
    .raddr_i(rd_idx_q), .rdata_o(ra_stat));

  // slot being examined: the one read last cycle
  logic [SlotW-1:0] cur;
  assign cur = cnt_q[SlotW-1:0];

  // final decision, combinational in StDone
  logic [SlotW-1:0] sidx;
  logic sfound, added, due, is_tick;
  out_word_t res;
  logic n_talk;
  logic [SlotW-1:0] n_tslot;
  logic [15:0] n_astream;
  logic [31:0] n_lft;
  logic [NumSlots-1:0] n_used, others;

  always_comb begin
    is_tick = in_q.req_type;
    sfound = hit_q || free_q;
    sidx = hit_q ? hit_idx_q : free_idx_q;
    added = !hit_q && free_q;
    res = '0;
    n_talk = talk_q;
    n_tslot = tslot_q;
    n_astream = astream_q;
    n_lft = lft_q;
    n_used = used_q;
    we_addr = 1'b0;
    we_poll = 1'b0;
    we_stat = 1'b0;
    w_stat = in_q.now_msec;
    wa_idx = sidx;
    due = 1'b0;
    others = used_q;
    others[hit_idx_q] = 1'b0;
    if (st_q == StDone) begin
      if (is_tick) begin
        res.action = ActTick;
        res.evicted_mask = MaskW'(evict_q);
        n_used = used_q & ~evict_q;
        if (talk_q && evict_q[tslot_q]) begin
          n_talk = 1'b0; n_tslot = '0; n_astream = '0;
          res.released = 1'b1; res.release_cause = CauseEvict;
        end
        if (n_talk && (in_q.now_msec - lft_q) > {16'd0, tto_q}) begin
          n_talk = 1'b0; n_tslot = '0; n_astream = '0;
          res.released = 1'b1; res.release_cause = CauseWdog;
        end
      end else if (!in_q.tag_ok) begin
        res.outcome = OutBadTag;
      end else begin
        unique case (in_q.pkt_kind)
          KindPoll: begin
            if (!sfound) begin
              res.outcome = OutFull;
            end else begin
              res.src_slot = SrcW'(sidx);
              n_used[sidx] = 1'b1;
              we_addr = added;
              we_poll = 1'b1;
              due = added || (sint_q != 16'd0 &&
                    (in_q.now_msec - hit_stat_q) >= sint_ms_q);
              if (sen_q && due) begin
                res.action = ActStatus;
                we_stat = 1'b1;
              end else if (added) begin
                we_stat = 1'b1;
                w_stat = '0;
              end
            end
          end
          KindHeader: begin
            if (in_q.pkt_len < hmin_q) begin
              res.outcome = OutShort;
            end else if (!sfound) begin
              res.outcome = OutFull;
            end else begin
              res.src_slot = SrcW'(sidx);
              n_used[sidx] = 1'b1;
              we_addr = added;
              we_poll = added;
              we_stat = added;
              w_stat = '0;
              if (talk_q && tslot_q != sidx) begin
                res.outcome = OutBusy;
              end else begin
                n_talk = 1'b1;
                n_tslot = sidx;
                n_astream = in_q.stream_id;
                n_lft = in_q.now_msec;
                res.action = ActHeader;
                others = used_q;
                others[sidx] = 1'b0;
                res.dest_mask = MaskW'(others);
              end
            end
          end
          KindData: begin
            if (in_q.pkt_len < dmin_q) begin
              res.outcome = OutShort;
            end else if (!hit_q) begin
              res.outcome = OutNotActv;
            end else begin
              res.src_slot = SrcW'(hit_idx_q);
              if (!talk_q || tslot_q != hit_idx_q || astream_q != in_q.stream_id) begin
                res.outcome = OutNotActv;
              end else begin
                n_lft = in_q.now_msec;
                res.action = ActData;
                res.dest_mask = MaskW'(others);
                if (in_q.end_flag) begin
                  n_talk = 1'b0; n_tslot = '0; n_astream = '0;
                  res.released = 1'b1; res.release_cause = CauseEot;
                end
              end
            end
          end
          default: res.outcome = OutIgnored;
        endcase
      end
    end
  end

  assign in_stall_o = (st_q != StIdle);
  assign out_valid_o = (st_q == StOut);
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      in_q <= '0;
      cto_q <= 16'd60; tto_q <= 16'd1000; sen_q <= 1'b1;
      sint_q <= 16'd0; hmin_q <= 16'd49; dmin_q <= 16'd21;
      used_q <= '0; evict_q <= '0;
      talk_q <= 1'b0; tslot_q <= '0; astream_q <= '0; lft_q <= '0;
      cnt_q <= '0; rd_idx_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0;
      hit_idx_q <= '0; free_idx_q <= '0; hit_stat_q <= '0;
      limit_q <= '0; sint_ms_q <= '0;
      out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegClientTo:  cto_q <= cfg_data_i;
          RegTalkerTo:  tto_q <= cfg_data_i;
          RegStatusEn:  sen_q <= cfg_data_i[0];
          RegStatusInt: sint_q <= cfg_data_i;
          RegHdrMin:    hmin_q <= cfg_data_i;
          RegDataMin:   dmin_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            in_q <= in_data_i;
            cnt_q <= '0;
            rd_idx_q <= '0;
            hit_q <= 1'b0;
            free_q <= 1'b0;
            evict_q <= '0;
            limit_q <= 32'(cto_q) * 32'(MsPerSec);
            sint_ms_q <= 32'(sint_q) * 32'(MsPerSec);
            st_q <= StRead;
          end
        end
        StRead: begin
          rd_idx_q <= SlotW'(1);
          st_q <= StScan;
        end
        StScan: begin
          if (used_q[cur]) begin
            if (ra_addr == in_q.addr_key && !hit_q) begin
              hit_q <= 1'b1; hit_idx_q <= cur; hit_stat_q <= ra_stat;
            end
            if ((in_q.now_msec - ra_poll) > limit_q) evict_q[cur] <= 1'b1;
          end else if (!free_q) begin
            free_q <= 1'b1; free_idx_q <= cur;
          end
          if (cnt_q == LastIdx) begin
            st_q <= StDone;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        StDone: begin
          out_q <= res;
          used_q <= n_used;
          talk_q <= n_talk; tslot_q <= n_tslot;
          astream_q <= n_astream; lft_q <= n_lft;
          st_q <= StOut;
        end
        StOut: begin
          if (!out_stall_i) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule
